@@ design/sims_pkg.sv @@
// Shared types and codes for the sorted interval merge set.
// Used by sims_cell, the top level and the port checker; depends on nothing.
`default_nettype none

package sims_pkg;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_BAD   = 2'd3
    } t_status;

    // Command broadcast from the sequencer to every cell in the row.
    typedef enum logic [2:0] {
        CMD_HOLD    = 3'd0,
        CMD_LOOK    = 3'd1,
        CMD_INSERT  = 3'd2,
        CMD_MERGE   = 3'd3,
        CMD_SQUEEZE = 3'd4,
        CMD_POP     = 3'd5
    } t_cell_cmd;

    // Per-cell flags reported back to the sequencer and to the neighbors.
    typedef struct packed {
        logic meet;   // entry overlaps or touches the pushed interval
        logic below;  // entry lies wholly below the pushed interval
        logic pair;   // first meeting entry, and its right neighbor meets too
    } t_cell_stat;

endpackage

`default_nettype wire

@@ design/sims_cell.sv @@
// One slot of the interval row: holds one entry and its compare flags.
// Trades data with its left and right neighbors; uses sims_pkg.
`default_nettype none

module sims_cell #(
    parameter int OFS_W = 48
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  sims_pkg::t_cell_cmd    i_cmd,
    input  wire                    i_occ,
    input  wire        [OFS_W-1:0] i_req_lo,
    input  wire        [OFS_W-1:0] i_req_hi,
    input  wire                    i_prev_below,
    input  wire        [OFS_W-1:0] i_left_lo,
    input  wire        [OFS_W-1:0] i_left_hi,
    input  wire        [OFS_W-1:0] i_right_lo,
    input  wire        [OFS_W-1:0] i_right_hi,
    input  wire                    i_right_meet,
    output logic       [OFS_W-1:0] o_lo,
    output logic       [OFS_W-1:0] o_hi,
    output sims_pkg::t_cell_stat   o_stat
);
    import sims_pkg::*;

    logic [OFS_W-1:0] r_lo, n_lo;
    logic [OFS_W-1:0] r_hi, n_hi;
    logic             r_meet, n_meet;
    logic             r_below, n_below;
    logic             first;
    logic             after;
    logic             ins_here;

    // Flags of a sorted, disjoint row make the meeting entries one contiguous run.
    assign first    = r_meet & i_prev_below;
    assign after    = ~i_prev_below;
    assign ins_here = ~r_below & i_prev_below;

    always_comb begin
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_meet  = r_meet;
        n_below = r_below;
        unique case (i_cmd)
            CMD_HOLD: begin
            end
            CMD_LOOK: begin
                n_meet  = i_occ & (r_hi >= i_req_lo) & (r_lo <= i_req_hi);
                n_below = i_occ & (r_hi < i_req_lo);
            end
            CMD_INSERT: begin
                if (ins_here) begin
                    n_lo = i_req_lo;
                    n_hi = i_req_hi;
                end else if (after) begin
                    n_lo = i_left_lo;
                    n_hi = i_left_hi;
                end
            end
            CMD_MERGE: begin
                if (first) begin
                    n_lo = (i_req_lo < r_lo) ? i_req_lo : r_lo;
                    n_hi = (i_req_hi > r_hi) ? i_req_hi : r_hi;
                end
            end
            CMD_SQUEEZE: begin
                // Absorb the right neighbor; everything behind moves one slot down.
                if (first) begin
                    n_hi = (i_right_hi > r_hi) ? i_right_hi : r_hi;
                end else if (after) begin
                    n_lo   = i_right_lo;
                    n_hi   = i_right_hi;
                    n_meet = i_right_meet;
                end
            end
            CMD_POP: begin
                n_lo = i_right_lo;
                n_hi = i_right_hi;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_lo <= n_lo;
        r_hi <= n_hi;
        if (!i_rst_n) begin
            r_meet  <= 1'b0;
            r_below <= 1'b0;
        end else begin
            r_meet  <= n_meet;
            r_below <= n_below;
        end
    end

    assign o_lo        = r_lo;
    assign o_hi        = r_hi;
    assign o_stat.meet  = r_meet;
    assign o_stat.below = r_below;
    assign o_stat.pair  = first & i_right_meet;

endmodule

`default_nettype wire

@@ design/sorted_interval_merge_set_core.sv @@
// Top level of the sorted interval merge set: sequencer plus a row of sims_cell.
// Uses sims_pkg for operation, status and cell command codes.
//
// Usage:
//   Request channel: drive i_operation, i_lower_bound, i_upper_bound with start;
//   the request is taken at a rising edge where start is high and busy is low.
//   Result channel: o_valid is high for exactly one cycle with o_status,
//   o_popped_lower, o_popped_upper and o_entry_count; the receiver must take it
//   then, as nothing can hold a result back.
//   Timing: after the accepting edge the row compares (S_LOOK) and applies
//   the request (S_APPLY). Pop, insert and rejected requests show their result
//   in the next cycle, and a new request can be accepted in the cycle the
//   result shows.
//   A push that merges widens the first meeting entry in S_APPLY, absorbs the
//   further stored entries of the run one by one in S_SQUEEZE, then closes in
//   S_SQUEEZE once no pair is left; the loop shifts one neighbor per cycle along the cell row.
//   Reset (synchronous, active low) empties the set and clears busy and o_valid;
//   stored bounds are not cleared, only the entry count.
`default_nettype none

module sorted_interval_merge_set_core #(
    parameter int TABLE_DEPTH = 16,
    parameter int OFFSET_BITS = 48,
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   start,
    output logic                  busy,
    input  wire                   i_operation,
    input  wire [OFFSET_BITS-1:0] i_lower_bound,
    input  wire [OFFSET_BITS-1:0] i_upper_bound,
    output logic                  o_valid,
    output logic [1:0]            o_status,
    output logic [OFFSET_BITS-1:0] o_popped_lower,
    output logic [OFFSET_BITS-1:0] o_popped_upper,
    output logic [CNT_W-1:0]      o_entry_count
);
    import sims_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_LOOK    = 4'b0010,
        S_APPLY   = 4'b0100,
        S_SQUEEZE = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_valid, n_valid;
    t_status          r_status, n_status;
    logic [OFFSET_BITS-1:0] r_plo, n_plo;
    logic [OFFSET_BITS-1:0] r_phi, n_phi;
    t_op              r_op;
    logic [OFFSET_BITS-1:0] r_lo;
    logic [OFFSET_BITS-1:0] r_hi;
    logic             r_bad;
    t_cell_cmd        cmd;
    logic             accept;

    logic [OFFSET_BITS-1:0] cell_lo [TABLE_DEPTH];
    logic [OFFSET_BITS-1:0] cell_hi [TABLE_DEPTH];
    t_cell_stat             cell_stat [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] meet_vec;
    logic [TABLE_DEPTH-1:0] pair_vec;
    logic                   any_meet;
    logic                   any_pair;

    assign accept = start & (r_state == S_IDLE);

    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        logic                   occ;
        logic                   prev_below;
        logic [OFFSET_BITS-1:0] left_lo;
        logic [OFFSET_BITS-1:0] left_hi;
        logic [OFFSET_BITS-1:0] right_lo;
        logic [OFFSET_BITS-1:0] right_hi;
        logic                   right_meet;

        assign occ = (CNT_W'(k) < r_count);

        if (k == 0) begin : g_first
            assign prev_below = 1'b1;
            assign left_lo    = '0;
            assign left_hi    = '0;
        end else begin : g_mid
            assign prev_below = cell_stat[k-1].below;
            assign left_lo    = cell_lo[k-1];
            assign left_hi    = cell_hi[k-1];
        end

        if (k == TABLE_DEPTH - 1) begin : g_last
            assign right_lo   = '0;
            assign right_hi   = '0;
            assign right_meet = 1'b0;
        end else begin : g_inner
            assign right_lo   = cell_lo[k+1];
            assign right_hi   = cell_hi[k+1];
            assign right_meet = cell_stat[k+1].meet;
        end

        sims_cell #(
            .OFS_W(OFFSET_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_occ        (occ),
            .i_req_lo     (r_lo),
            .i_req_hi     (r_hi),
            .i_prev_below (prev_below),
            .i_left_lo    (left_lo),
            .i_left_hi    (left_hi),
            .i_right_lo   (right_lo),
            .i_right_hi   (right_hi),
            .i_right_meet (right_meet),
            .o_lo         (cell_lo[k]),
            .o_hi         (cell_hi[k]),
            .o_stat       (cell_stat[k])
        );

        assign meet_vec[k] = cell_stat[k].meet;
        assign pair_vec[k] = cell_stat[k].pair;
    end

    assign any_meet = |meet_vec;
    assign any_pair = |pair_vec;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_valid  = 1'b0;
        n_status = r_status;
        n_plo    = r_plo;
        n_phi    = r_phi;
        cmd      = CMD_HOLD;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                cmd     = CMD_LOOK;
                n_state = S_APPLY;
            end
            S_APPLY: begin
                n_state  = S_IDLE;
                n_valid  = 1'b1;
                n_status = ST_OK;
                n_plo    = '0;
                n_phi    = '0;
                if (r_op == OP_POP) begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        cmd     = CMD_POP;
                        n_plo   = cell_lo[0];
                        n_phi   = cell_hi[0];
                        n_count = r_count - 1'b1;
                    end
                end else if (r_bad) begin
                    n_status = ST_BAD;
                end else if (any_meet) begin
                    // Widen the first meeting entry, then absorb the rest of the run.
                    cmd     = CMD_MERGE;
                    n_valid = 1'b0;
                    n_state = S_SQUEEZE;
                end else if (r_count == CNT_W'(TABLE_DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    cmd     = CMD_INSERT;
                    n_count = r_count + 1'b1;
                end
            end
            S_SQUEEZE: begin
                if (any_pair) begin
                    cmd     = CMD_SQUEEZE;
                    n_count = r_count - 1'b1;
                end else begin
                    n_state  = S_IDLE;
                    n_valid  = 1'b1;
                    n_status = ST_OK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_plo    <= n_plo;
        r_phi    <= n_phi;
        if (accept) begin
            r_op  <= t_op'(i_operation);
            r_lo  <= i_lower_bound;
            r_hi  <= i_upper_bound;
            r_bad <= (i_lower_bound > i_upper_bound);
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_popped_lower = r_plo;
    assign o_popped_upper = r_phi;
    assign o_entry_count  = r_count;

endmodule

`default_nettype wire

@@ design/sims_checker.sv @@
// Port-level checks for sorted_interval_merge_set_core, bound to every instance.
// Sees only the top-level ports; uses sims_pkg status codes.
`default_nettype none

module sims_checker #(
    parameter int TABLE_DEPTH = 16,
    parameter int OFFSET_BITS = 48,
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   start,
    input wire                   busy,
    input wire                   o_valid,
    input wire [1:0]             o_status,
    input wire [OFFSET_BITS-1:0] o_popped_lower,
    input wire [OFFSET_BITS-1:0] o_popped_upper,
    input wire [CNT_W-1:0]       o_entry_count
);
    import sims_pkg::*;

    // An accepted request keeps the block busy and shows no result through the compare and apply steps.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid) ##1 (busy && !o_valid))
        else $error("request accepted but block not busy or result too early");

    // A result strobe lasts one cycle and the block is free while it shows.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy ##1 !o_valid)
        else $error("result strobe longer than one cycle or shown while busy");

    // Popped bounds are zero on every result whose status is not OK.
    a_pop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |->
            (o_popped_lower == '0 && o_popped_upper == '0))
        else $error("nonzero popped bounds on a failed request");

    // Empty pop reports an empty set; the count never passes the table depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_entry_count <= CNT_W'(TABLE_DEPTH)) &&
            (o_status != ST_EMPTY || o_entry_count == '0))
        else $error("entry count out of range or inconsistent with status");

endmodule

bind sorted_interval_merge_set_core sims_checker #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .OFFSET_BITS(OFFSET_BITS)
) u_sims_checker (.*);

`default_nettype wire
